[rtl/event_coalescing_timeout_table_top_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef EVENT_COALESCING_TIMEOUT_TABLE_TOP_MACROS_SVH
`define EVENT_COALESCING_TIMEOUT_TABLE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ECT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ECT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/ect_pkg.sv]
// ----------------------------------------------------------------------------
// ect_pkg
// Types and constants of the event coalescing timeout table.
// ----------------------------------------------------------------------------
package ect_pkg;
  localparam int TABLE_SIZE = 16;
  localparam int KEY_BITS   = 32;
  localparam int TIME_BITS  = 32;
  localparam int IDX_BITS   = $clog2(TABLE_SIZE);
  localparam int CNT_BITS   = $clog2(TABLE_SIZE + 1);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic                latch_in;  // capture the accepted item
    logic                do_push;   // apply the push to the table
    logic                load_rank; // point the rank cursor at its first value
    logic                step_rank; // advance the rank cursor
    logic                emit;      // load output with the selected entry, free it
    logic                renumber;  // compact ranks after a tick
    logic                out_ack;   // load output with push acknowledgement
    logic                out_empty; // load output with empty last item
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    req_t req;
    logic hit;        // some valid slot holds the selected rank
    logic due;        // that slot is due under the current request
    logic rank_last;  // cursor at its final rank
    logic emitted;    // at least one entry emitted for this item
    logic more_after; // a later rank still holds an entry to emit
  } status_t;
endpackage

[rtl/ect_if.sv]
// ----------------------------------------------------------------------------
// ect_in_if / ect_out_if
// Valid-ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface ect_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] event_key;
  logic [31:0] event_mask;
  logic [31:0] event_cookie;
  logic [31:0] now_time;
  modport source (output valid, req_type, event_key, event_mask, event_cookie,
                  now_time, input ready);
  modport sink (input valid, req_type, event_key, event_mask, event_cookie,
                now_time, output ready);
endinterface

interface ect_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        push_status;
  logic [31:0] out_key;
  logic [31:0] out_mask;
  logic [31:0] out_cookie;
  logic        last_result;
  modport source (output valid, result_kind, push_status, out_key, out_mask,
                  out_cookie, last_result, input ready);
  modport sink (input valid, result_kind, push_status, out_key, out_mask,
                out_cookie, last_result, output ready);
endinterface

[rtl/event_coalescing_timeout_table_top.sv]
// ----------------------------------------------------------------------------
// event_coalescing_timeout_table_top
// Keyed event coalescing table with quiet-window flush.
// ----------------------------------------------------------------------------
// The host sends request items on the in channel (valid/ready): a push that
// merges an event into the entry with the same key or creates one, a tick
// that emits every entry that has been quiet for at least quiet_window time
// units (oldest created first), or a flush that emits every entry, newest
// created first. Each request gives one or more result items on the out
// channel; last_result marks the final one. A push answers with one
// acknowledgement carrying the full flag.
// A push is applied and acknowledged in ST_PUSH once the output register is
// free. A tick or flush loads the rank cursor in ST_PUSH, walks the ranks in
// ST_SCAN one rank at a time and finishes in ST_DONE.
// The block takes one item at a time; ready is high only when idle.
// The quiet_window register is written through cfg_we/cfg_wdata and resets
// to 500. Synchronous reset clears all valid marks and the sequencer.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds until it is taken; nothing is dropped.
// ----------------------------------------------------------------------------
module event_coalescing_timeout_table_top
  import ect_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ect_in_if.sink      in_ch,
  ect_out_if.source   out_ch
);
  // Quiet window register.
  logic [31:0] quiet_window_r;
  always_ff @(posedge clk) begin
    if (!rst_n) quiet_window_r <= 32'd500;
    else if (cfg_we) quiet_window_r <= cfg_wdata;
  end

  cmd_t    cmd;
  status_t sts;

  // The sequencer decides what to do each cycle.
  ect_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // The datapath holds the slot table and output register.
  ect_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .quiet_window(quiet_window_r),
    .in_req_type(in_ch.req_type), .in_event_key(in_ch.event_key),
    .in_event_mask(in_ch.event_mask), .in_event_cookie(in_ch.event_cookie),
    .in_now_time(in_ch.now_time),
    .o_kind(out_ch.result_kind), .o_status(out_ch.push_status),
    .o_key(out_ch.out_key), .o_mask(out_ch.out_mask),
    .o_cookie(out_ch.out_cookie), .o_last(out_ch.last_result)
  );
endmodule

[rtl/ect_datapath.sv]
// ----------------------------------------------------------------------------
// ect_datapath
// Slot table, rank cursor and output register of the coalescing table.
// ----------------------------------------------------------------------------
module ect_datapath
  import ect_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output status_t       sts,
  input  logic [31:0]   quiet_window,
  input  logic [1:0]    in_req_type,
  input  logic [31:0]   in_event_key,
  input  logic [31:0]   in_event_mask,
  input  logic [31:0]   in_event_cookie,
  input  logic [31:0]   in_now_time,
  output logic [1:0]    o_kind,
  output logic          o_status,
  output logic [31:0]   o_key,
  output logic [31:0]   o_mask,
  output logic [31:0]   o_cookie,
  output logic          o_last
);
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r    [TABLE_SIZE];
  logic [31:0]           mask_r   [TABLE_SIZE];
  logic [31:0]           cookie_r [TABLE_SIZE];
  logic [TIME_BITS-1:0]  time_r   [TABLE_SIZE];
  logic [IDX_BITS-1:0]   rank_r   [TABLE_SIZE];

  req_t                 req_r;
  logic [KEY_BITS-1:0]  ikey_r;
  logic [31:0]          imask_r, icookie_r;
  logic [TIME_BITS-1:0] inow_r;
  logic [IDX_BITS-1:0]  cur_r;
  logic                 emitted_r;

  // Per-slot compares, each a fixed place of its own.
  logic [TABLE_SIZE-1:0] key_hit, rank_hit, due_vec;
  logic [IDX_BITS-1:0]   hit_idx, free_idx, sel_idx;
  logic                  any_hit, any_free;
  logic [CNT_BITS-1:0]   vcount;

  always_comb begin
    any_hit = 1'b0; any_free = 1'b0;
    hit_idx = '0; free_idx = '0; sel_idx = '0;
    vcount = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      key_hit[i]  = valid_r[i] && (key_r[i] == ikey_r);
      rank_hit[i] = valid_r[i] && (rank_r[i] == cur_r);
      due_vec[i]  = (inow_r - time_r[i]) >= TIME_BITS'(quiet_window);
      vcount = vcount + CNT_BITS'(valid_r[i]);
    end
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (key_hit[i]) begin
        any_hit = 1'b1; hit_idx = IDX_BITS'(i);
      end
      if (!valid_r[i]) begin
        any_free = 1'b1; free_idx = IDX_BITS'(i);
      end
      if (rank_hit[i]) sel_idx = IDX_BITS'(i);
    end
  end

  // Another entry to emit later in the walk (sets the last flag of an emit).
  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (valid_r[i] && i != int'(sel_idx)) begin
        if (req_r == REQ_TICK) begin
          if (rank_r[i] > cur_r && due_vec[i]) more_after = 1'b1;
        end else if (rank_r[i] < cur_r) begin
          more_after = 1'b1;
        end
      end
    end
  end

  assign sts.req        = req_r;
  assign sts.hit        = |rank_hit;
  assign sts.due        = (req_r == REQ_FLUSH) || due_vec[sel_idx];
  assign sts.rank_last  = (req_r == REQ_TICK) ? (cur_r == IDX_BITS'(TABLE_SIZE - 1))
                                              : (cur_r == '0);
  assign sts.emitted    = emitted_r;
  assign sts.more_after = more_after;

  // Rank compaction after a tick: new rank counts surviving older entries.
  logic [IDX_BITS-1:0] new_rank [TABLE_SIZE];
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      new_rank[i] = '0;
      for (int j = 0; j < TABLE_SIZE; j++)
        if (valid_r[j] && rank_r[j] < rank_r[i]) new_rank[i] = new_rank[i] + 1'b1;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.do_push && !any_hit && any_free) valid_nxt[free_idx] = 1'b1;
    if (cmd.emit) valid_nxt[sel_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      emitted_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.latch_in) emitted_r <= 1'b0;
      else if (cmd.emit) emitted_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r     <= req_t'(in_req_type);
      ikey_r    <= KEY_BITS'(in_event_key);
      imask_r   <= in_event_mask;
      icookie_r <= in_event_cookie;
      inow_r    <= TIME_BITS'(in_now_time);
    end
    if (cmd.load_rank)
      cur_r <= (req_r == REQ_TICK) ? '0 : IDX_BITS'(vcount - 1'b1);
    else if (cmd.step_rank)
      cur_r <= (req_r == REQ_TICK) ? cur_r + 1'b1 : cur_r - 1'b1;
    if (cmd.do_push) begin
      if (any_hit) begin
        mask_r[hit_idx] <= mask_r[hit_idx] | imask_r;
        time_r[hit_idx] <= inow_r;
        if (icookie_r != '0) cookie_r[hit_idx] <= icookie_r;
      end else if (any_free) begin
        key_r[free_idx]    <= ikey_r;
        mask_r[free_idx]   <= imask_r;
        cookie_r[free_idx] <= icookie_r;
        time_r[free_idx]   <= inow_r;
        rank_r[free_idx]   <= IDX_BITS'(vcount);
      end
    end
    if (cmd.renumber)
      for (int i = 0; i < TABLE_SIZE; i++) rank_r[i] <= new_rank[i];
    if (cmd.emit) begin
      o_kind   <= KIND_ENTRY;
      o_status <= 1'b0;
      o_key    <= 32'(key_r[sel_idx]);
      o_mask   <= mask_r[sel_idx];
      o_cookie <= cookie_r[sel_idx];
      o_last   <= !more_after;
    end else if (cmd.out_ack) begin
      o_kind   <= KIND_ACK;
      o_status <= !any_hit && !any_free;
      o_key    <= '0; o_mask <= '0; o_cookie <= '0;
      o_last   <= 1'b1;
    end else if (cmd.out_empty) begin
      o_kind   <= KIND_EMPTY;
      o_status <= 1'b0;
      o_key    <= '0; o_mask <= '0; o_cookie <= '0;
      o_last   <= 1'b1;
    end
  end

`include "event_coalescing_timeout_table_top_macros.svh"
  `ECT_ASSERT_NXT(a_push_sets, clk, rst_n, cmd.do_push && !any_hit && any_free, valid_r[$past(free_idx)], "push did not fill slot")
  `ECT_ASSERT_NXT(a_emit_frees, clk, rst_n, cmd.emit && !cmd.do_push, !valid_r[$past(sel_idx)], "emit left slot valid")
  `ECT_ASSERT_IMP(a_one_hit, clk, rst_n, 1'b1, $onehot0(key_hit), "key held by two slots")
endmodule

[rtl/ect_ctrl.sv]
// ----------------------------------------------------------------------------
// ect_ctrl
// Sequencer for request items; walks the table ranks for ticks and flushes.
// ----------------------------------------------------------------------------
module ect_ctrl
  import ect_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);
  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  assign out_valid = ovalid_r;
  wire out_free = !ovalid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    in_ready   = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        case (sts.req)
          REQ_PUSH: begin
            if (out_free) begin
              cmd.do_push = 1'b1; cmd.out_ack = 1'b1;
              ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
            end
          end
          REQ_TICK, REQ_FLUSH: begin
            cmd.load_rank = 1'b1; state_nxt = ST_SCAN;
          end
          default: begin
            if (out_free) begin
              cmd.out_empty = 1'b1; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.hit && sts.due) begin
          if (out_free) begin
            cmd.emit = 1'b1; ovalid_nxt = 1'b1;
            if (sts.rank_last || !sts.more_after) state_nxt = ST_DONE;
            else cmd.step_rank = 1'b1;
          end
        end else if (sts.rank_last || !sts.hit) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step_rank = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.req == REQ_TICK) cmd.renumber = 1'b1;
        if (sts.emitted) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.out_empty = 1'b1; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`include "event_coalescing_timeout_table_top_macros.svh"
  `ECT_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE, "ready outside idle")
  `ECT_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !(cmd.emit || cmd.out_ack || cmd.out_empty), "result overwritten")
  `ECT_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.emit || cmd.out_ack || cmd.out_empty, out_valid, "result not shown")
endmodule

[tb/tb_event_coalescing_timeout_table_top.sv]
// ----------------------------------------------------------------------------
// tb_event_coalescing_timeout_table_top
// Self-checking bench for the event coalescing timeout table.
// ----------------------------------------------------------------------------
// Request items are queued by the stimulus process and driven by a clocked
// driver with random gaps; result items are checked by a clocked monitor
// with random stalls. A predictor keeps its own copy of the table and turns
// each accepted request into the result items it should produce.
// ----------------------------------------------------------------------------
module tb_event_coalescing_timeout_table_top
  import ect_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_t        req;
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] cookie;
    logic [31:0] now;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] cookie;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  ect_in_if  in_ch ();
  ect_out_if out_ch ();

  event_coalescing_timeout_table_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the table. Rank 0 is the oldest created entry.
  logic [31:0] win_q;
  logic        tv [TABLE_SIZE];
  logic [31:0] tkey [TABLE_SIZE];
  logic [31:0] tmask [TABLE_SIZE];
  logic [31:0] tcookie [TABLE_SIZE];
  logic [31:0] tlast [TABLE_SIZE];
  int          trank [TABLE_SIZE];

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       errors = 0;
  int       accepted = 0;
  int       queued = 0;
  logic [31:0] clock_now = 0;
  logic [31:0] keys_pool[8];

  function automatic result_t mk(logic [1:0] kind, logic st, logic [31:0] k,
                                 logic [31:0] m, logic [31:0] c, logic l);
    result_t r;
    r.kind = kind; r.status = st; r.key = k; r.mask = m; r.cookie = c; r.last = l;
    return r;
  endfunction

  function automatic int slot_of_rank(int r);
    for (int i = 0; i < TABLE_SIZE; i++)
      if (tv[i] && trank[i] == r) return i;
    return -1;
  endfunction

  // Applies one request to the predictor table and queues its results.
  task automatic predict_results(request_t q);
    int n;
    int s;
    int freeslot;
    int cnt;
    int next;
    logic was [TABLE_SIZE];
    n = 0;
    freeslot = -1;
    cnt = 0;
    if (q.req == REQ_PUSH) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (tv[i] && tkey[i] == q.key) begin
          tmask[i] |= q.mask;
          tlast[i] = q.now;
          if (q.cookie != 0) tcookie[i] = q.cookie;
          expected_results.push_back(mk(KIND_ACK, 1'b0, 0, 0, 0, 1'b1));
          return;
        end
        if (tv[i]) cnt++;
        else if (freeslot < 0) freeslot = i;
      end
      if (freeslot < 0) begin
        expected_results.push_back(mk(KIND_ACK, 1'b1, 0, 0, 0, 1'b1));
        return;
      end
      tv[freeslot] = 1'b1; trank[freeslot] = cnt; tkey[freeslot] = q.key;
      tmask[freeslot] = q.mask; tcookie[freeslot] = q.cookie; tlast[freeslot] = q.now;
      expected_results.push_back(mk(KIND_ACK, 1'b0, 0, 0, 0, 1'b1));
      return;
    end
    if (q.req == REQ_TICK) begin
      for (int i = 0; i < TABLE_SIZE; i++) was[i] = tv[i];
      for (int r = 0; r < TABLE_SIZE; r++) begin
        s = slot_of_rank(r);
        if (s >= 0 && (q.now - tlast[s]) >= win_q) begin
          expected_results.push_back(mk(KIND_ENTRY, 1'b0, tkey[s], tmask[s],
                                        tcookie[s], 1'b0));
          tv[s] = 1'b0;
          n++;
        end
      end
      // Survivors keep their order with dense ranks.
      next = 0;
      for (int r = 0; r < TABLE_SIZE; r++)
        for (int i = 0; i < TABLE_SIZE; i++)
          if (was[i] && tv[i] && trank[i] == r) begin
            trank[i] = next;
            next++;
          end
    end else if (q.req == REQ_FLUSH) begin
      for (int r = TABLE_SIZE - 1; r >= 0; r--) begin
        s = slot_of_rank(r);
        if (s >= 0) begin
          expected_results.push_back(mk(KIND_ENTRY, 1'b0, tkey[s], tmask[s],
                                        tcookie[s], 1'b0));
          tv[s] = 1'b0;
          n++;
        end
      end
    end
    if (n == 0) expected_results.push_back(mk(KIND_EMPTY, 1'b0, 0, 0, 0, 1'b1));
    else expected_results[$].last = 1'b1;
  endtask

  // Driver: one item at a time from the pending queue, random gap before each.
  int in_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.event_key = '0;
    in_ch.event_mask = '0;
    in_ch.event_cookie = '0;
    in_ch.now_time = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_results('{req_t'(in_ch.req_type), in_ch.event_key, in_ch.event_mask,
                          in_ch.event_cookie, in_ch.now_time});
        accepted <= accepted + 1;
        in_gap = $urandom_range(0, 5);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t q;
          q = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= q.req;
          in_ch.event_key <= q.key;
          in_ch.event_mask <= q.mask;
          in_ch.event_cookie <= q.cookie;
          in_ch.now_time <= q.now;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall per result item, field by field compare.
  int out_stall = 0;
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (out_ch.result_kind !== e.kind) begin
            $error("result_kind expected %0d actual %0d", e.kind, out_ch.result_kind);
            errors++;
          end
          if (out_ch.push_status !== e.status) begin
            $error("push_status expected %0d actual %0d", e.status, out_ch.push_status);
            errors++;
          end
          if (out_ch.out_key !== e.key) begin
            $error("out_key expected %h actual %h", e.key, out_ch.out_key);
            errors++;
          end
          if (out_ch.out_mask !== e.mask) begin
            $error("out_mask expected %h actual %h", e.mask, out_ch.out_mask);
            errors++;
          end
          if (out_ch.out_cookie !== e.cookie) begin
            $error("out_cookie expected %h actual %h", e.cookie, out_ch.out_cookie);
            errors++;
          end
          if (out_ch.last_result !== e.last) begin
            $error("last_result expected %0d actual %0d", e.last, out_ch.last_result);
            errors++;
          end
        end
        out_stall = $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(req_t rq, logic [31:0] k, logic [31:0] m,
                         logic [31:0] c, logic [31:0] t);
    pending_reqs.push_back('{rq, k, m, c, t});
    queued++;
  endtask

  // Waits until every queued item was accepted and every result came back.
  task automatic drain();
    while (accepted != queued || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_q = w;
  endtask

  // Random phase: mostly pushes over a small key pool so merges and a full
  // table happen, with ticks that advance time past or short of the window.
  task automatic random_phase(int count);
    int sel;
    logic [31:0] k;
    for (int j = 0; j < count; j++) begin
      sel = $urandom_range(0, 99);
      clock_now += $urandom_range(0, 300);
      if (sel < 2) clock_now = $urandom;
      k = ($urandom_range(0, 3) == 0) ? $urandom : keys_pool[$urandom_range(0, 7)];
      if (sel < 65)
        add_req(REQ_PUSH, k, $urandom, ($urandom_range(0, 2) == 0) ? 0 : $urandom,
                clock_now);
      else if (sel < 88)
        add_req(REQ_TICK, $urandom, $urandom, $urandom, clock_now);
      else if (sel < 97)
        add_req(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
      else
        add_req(REQ_NONE, $urandom, $urandom, $urandom, $urandom);
    end
    drain();
  endtask

  initial begin
    win_q = 32'd500;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tv[i] = 1'b0; trank[i] = 0;
    end
    for (int i = 0; i < 8; i++) keys_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset window, empty table cases, merges, full table.
    add_req(REQ_TICK, 0, 0, 0, 32'd1000);
    add_req(REQ_FLUSH, 0, 0, 0, 0);
    add_req(REQ_NONE, '1, '1, '1, '1);
    add_req(REQ_PUSH, 32'h0, 32'h0, 32'h0, 32'h0);
    add_req(REQ_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(REQ_PUSH, 32'h0, 32'h5555_5555, 32'h0, 32'd10);
    add_req(REQ_PUSH, 32'h0, 32'hAAAA_0000, 32'h1234, 32'd20);
    add_req(REQ_TICK, 0, 0, 0, 32'd400);
    add_req(REQ_TICK, 0, 0, 0, 32'd520);
    for (int i = 0; i < TABLE_SIZE; i++)
      add_req(REQ_PUSH, 32'h100 + i, 1 << i, i, 32'd600 + i);
    add_req(REQ_PUSH, 32'hDEAD, 1, 1, 32'd700);
    add_req(REQ_FLUSH, 0, 0, 0, 0);
    drain();

    // Wrapping quiet time with a zero window: every entry is due.
    write_window(32'd0);
    add_req(REQ_PUSH, 32'h77, 1, 0, 32'hFFFF_FFF0);
    add_req(REQ_TICK, 0, 0, 0, 32'h0000_0005);
    drain();
    random_phase(60);

    write_window(32'hFFFF_FFFF);
    add_req(REQ_PUSH, 32'h88, 2, 3, 32'd1);
    add_req(REQ_TICK, 0, 0, 0, 32'd0);
    add_req(REQ_TICK, 0, 0, 0, 32'd1);
    drain();
    random_phase(40);

    write_window(32'd400);
    random_phase(90);
    write_window(32'd150);
    random_phase(60);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/ect_pkg.sv
rtl/ect_if.sv
rtl/ect_datapath.sv
rtl/ect_ctrl.sv
rtl/event_coalescing_timeout_table_top.sv
tb/tb_event_coalescing_timeout_table_top.sv
